@@ design/mlpc_pkg.sv @@
package mlpc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_DIV,
        ST_LIGHT,
        ST_FINISH
    } state_t;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_SET_MODE = 3'd1;
    localparam logic [2:0] CMD_WINDOW   = 3'd2;
    localparam logic [2:0] CMD_BREATHE  = 3'd3;
    localparam logic [2:0] CMD_RUNNING  = 3'd4;
    localparam logic [2:0] CMD_RESTART  = 3'd5;

    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_BLINK   = 3'd1;
    localparam logic [2:0] MODE_DOUBLE  = 3'd2;
    localparam logic [2:0] MODE_SLOW    = 3'd3;
    localparam logic [2:0] MODE_ON      = 3'd4;
    localparam logic [2:0] MODE_PWM     = 3'd5;
    localparam logic [2:0] MODE_BREATHE = 3'd6;
    localparam logic [2:0] MODE_HOLD    = 3'd7;

    localparam logic CFG_PWM_PERIOD = 1'b0;
    localparam logic CFG_STEP_TICKS = 1'b1;

    localparam logic [31:0] BLINK_ON_END   = 32'd100;
    localparam logic [31:0] BLINK_RESTART  = 32'd1300;
    localparam logic [31:0] SLOW_RESTART   = 32'd3000;
    localparam logic [31:0] DOUBLE_ON1_END = 32'd50;
    localparam logic [31:0] DOUBLE_ON2_BEG = 32'd150;
    localparam logic [31:0] DOUBLE_ON2_END = 32'd200;
    localparam logic [31:0] DOUBLE_RESTART = 32'd1000;

    localparam logic [15:0] RESET_PERIOD = 16'd20;
    localparam logic [15:0] RESET_STEP   = 16'd20;

    localparam int DIV_STEPS = 16;

endpackage

@@ design/multi_led_pattern_controller_unit.sv @@
// Pattern engine for up to six LEDs, one result transaction per input transaction.
// A small sequencer visits the per-LED state one entry per cycle through a single
// shared update unit. A tick walks the LEDs one per cycle in ST_TICK and then goes
// to ST_FINISH. A running light first runs 16 divider steps (one quotient bit per
// cycle) and then walks the LEDs. Set mode, set window, start breathing and restart
// timing on an LED that exists pass through ST_EXEC to ST_FINISH, and an ignored
// command (index out of range, zero light count, unused code) goes straight to
// ST_FINISH. The input stays stalled until the result is loaded into the output
// register, and it is ready again in the cycle in which that result is valid there.
// A finished result may wait in the output register while the next item is
// accepted; a second result waits in the last step until it is taken.
module multi_led_pattern_controller_unit #(
    parameter int LED_COUNT = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [2:0]  led_index,
    input  logic [2:0]  new_mode,
    input  logic [15:0] window_start,
    input  logic [15:0] window_end,
    input  logic [15:0] pwm_period,
    input  logic [5:0]  led_mask,
    input  logic [5:0]  light_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  led_levels,
    output logic [2:0]  selected_mode,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import mlpc_pkg::*;

    localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [IW-1:0] LAST_LED = IW'(LED_COUNT - 1);

    state_t state_reg, state_next;

    logic [15:0] cfg_period_reg, cfg_step_reg;

    logic [2:0]  cmd_reg;
    logic [2:0]  idx_reg;
    logic [2:0]  nmode_reg;
    logic [15:0] wstart_reg, wend_reg, per_reg;
    logic [5:0]  mask_reg, lcnt_reg;

    logic [IW-1:0] led_reg, led_next;
    logic [3:0]    step_reg, step_next;
    logic [5:0]    rem_reg, rem_next;
    logic [15:0]   quo_reg, quo_next;
    logic [18:0]   acc_reg, acc_next;

    logic [2:0]  mode_tab   [LED_COUNT];
    logic [31:0] el_tab     [LED_COUNT];
    logic [31:0] last_tab   [LED_COUNT];
    logic [15:0] start_tab  [LED_COUNT];
    logic [15:0] end_tab    [LED_COUNT];
    logic [15:0] per_tab    [LED_COUNT];
    logic [31:0] be_tab     [LED_COUNT];
    logic        dir_tab    [LED_COUNT];
    logic [5:0]  pin_reg, pin_next;

    logic        out_valid_reg;
    logic [5:0]  led_levels_reg;
    logic [2:0]  selected_mode_reg;
    logic        load_out;

    // Index range check kept from acceptance for the result's mode field.
    logic idx_ok_reg;

    logic          idx_ok;
    logic [IW-1:0] addr;
    logic          ent_we;

    logic [2:0]  cur_mode, mode_n;
    logic [31:0] cur_el, el_n, cur_last, last_n, cur_be, be_n, e;
    logic [15:0] cur_start, start_n, cur_end, end_n, cur_per, per_n;
    logic        cur_dir, dir_n, pin_bit;

    logic [6:0]  trial;
    logic [19:0] acc_sum;

    assign idx_ok    = (led_index < 3'(LED_COUNT));
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign out_valid     = out_valid_reg;
    assign led_levels    = led_levels_reg;
    assign selected_mode = selected_mode_reg;

    always_comb
    begin
        if (state_reg == ST_TICK || state_reg == ST_LIGHT)
        begin
            addr = led_reg;
        end
        else
        begin
            addr = idx_reg[IW-1:0];
        end
    end

    assign cur_mode  = mode_tab[addr];
    assign cur_el    = el_tab[addr];
    assign cur_last  = last_tab[addr];
    assign cur_start = start_tab[addr];
    assign cur_end   = end_tab[addr];
    assign cur_per   = per_tab[addr];
    assign cur_be    = be_tab[addr];
    assign cur_dir   = dir_tab[addr];

    assign e       = cur_el + 32'd1;
    assign trial   = {rem_reg, quo_reg[15]};
    assign acc_sum = {1'b0, acc_reg} + {4'd0, quo_reg};

    always_comb
    begin
        state_next = state_reg;
        led_next   = led_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        acc_next   = acc_reg;
        load_out   = 1'b0;
        ent_we     = 1'b0;
        pin_next   = pin_reg;
        pin_bit    = pin_reg[addr];
        mode_n     = cur_mode;
        el_n       = cur_el;
        last_n     = cur_last;
        start_n    = cur_start;
        end_n      = cur_end;
        per_n      = cur_per;
        be_n       = cur_be;
        dir_n      = cur_dir;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    led_next  = '0;
                    step_next = '0;
                    rem_next  = '0;
                    quo_next  = pwm_period;
                    acc_next  = '0;
                    priority if (command == CMD_TICK)
                    begin
                        state_next = ST_TICK;
                    end
                    else if (command == CMD_RUNNING && light_count != 6'd0)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (idx_ok && (command == CMD_SET_MODE ||
                             command == CMD_WINDOW || command == CMD_BREATHE ||
                             command == CMD_RESTART))
                    begin
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_EXEC:
            begin
                ent_we = 1'b1;
                priority case (cmd_reg)
                    CMD_SET_MODE: mode_n = nmode_reg;
                    CMD_WINDOW:
                    begin
                        start_n = wstart_reg;
                        end_n   = wend_reg;
                        per_n   = per_reg;
                    end
                    CMD_BREATHE:
                    begin
                        per_n   = cfg_period_reg;
                        start_n = '0;
                        end_n   = '0;
                        dir_n   = 1'b0;
                        be_n    = '0;
                    end
                    default: el_n = '0;
                endcase
                state_next = ST_FINISH;
            end

            ST_TICK:
            begin
                ent_we = 1'b1;
                el_n   = e;
                be_n   = cur_be + 32'd1;
                unique case (cur_mode)
                    MODE_BLINK, MODE_SLOW:
                    begin
                        if (cur_last != e)
                        begin
                            last_n = e;
                            if (e < BLINK_ON_END)
                            begin
                                pin_bit = 1'b1;
                            end
                            else
                            begin
                                pin_bit = 1'b0;
                                if (e >= ((cur_mode == MODE_BLINK) ? BLINK_RESTART
                                                                   : SLOW_RESTART))
                                begin
                                    el_n = '0;
                                end
                            end
                        end
                    end
                    MODE_DOUBLE:
                    begin
                        if (cur_last != e)
                        begin
                            last_n = e;
                            priority if (e < DOUBLE_ON1_END)
                                pin_bit = 1'b1;
                            else if (e < DOUBLE_ON2_BEG)
                                pin_bit = 1'b0;
                            else if (e < DOUBLE_ON2_END)
                                pin_bit = 1'b1;
                            else if (e < DOUBLE_RESTART)
                                pin_bit = 1'b0;
                            else
                                el_n = '0;
                        end
                    end
                    MODE_ON:
                    begin
                        pin_bit = 1'b1;
                    end
                    MODE_PWM, MODE_BREATHE:
                    begin
                        if (e >= {16'd0, cur_per})
                        begin
                            el_n = '0;
                        end
                        if (cur_last != e)
                        begin
                            last_n  = e;
                            pin_bit = (e >= {16'd0, cur_start}) && (e < {16'd0, cur_end});
                        end
                        // The ramp uses the window end only after the pin is decided.
                        if (cur_mode == MODE_BREATHE && be_n >= {16'd0, cfg_step_reg})
                        begin
                            be_n = '0;
                            if (!cur_dir)
                            begin
                                if (cur_end < cur_per)
                                    end_n = cur_end + 16'd1;
                                else
                                    dir_n = 1'b1;
                            end
                            else
                            begin
                                if (cur_end != 16'd0)
                                    end_n = cur_end - 16'd1;
                                else
                                    dir_n = 1'b0;
                            end
                        end
                    end
                    MODE_HOLD:
                    begin
                        pin_bit = pin_reg[addr];
                    end
                    default:
                    begin
                        pin_bit = 1'b0;
                    end
                endcase
                pin_next[addr] = pin_bit;
                if (led_reg == LAST_LED)
                    state_next = ST_FINISH;
                else
                    led_next = led_reg + IW'(1);
            end

            ST_DIV:
            begin
                if (trial >= {1'b0, lcnt_reg})
                begin
                    rem_next = 6'(trial - {1'b0, lcnt_reg});
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[5:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(DIV_STEPS - 1))
                    state_next = ST_LIGHT;
            end

            ST_LIGHT:
            begin
                if (mask_reg[addr])
                begin
                    ent_we   = 1'b1;
                    start_n  = (acc_reg > 19'd65535) ? 16'hFFFF : acc_reg[15:0];
                    end_n    = (acc_sum > 20'd65535) ? 16'hFFFF : acc_sum[15:0];
                    per_n    = per_reg;
                    mode_n   = MODE_PWM;
                    el_n     = '0;
                    acc_next = acc_sum[18:0];
                end
                if (led_reg == LAST_LED)
                    state_next = ST_FINISH;
                else
                    led_next = led_reg + IW'(1);
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_period_reg <= RESET_PERIOD;
            cfg_step_reg   <= RESET_STEP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_PWM_PERIOD)
                cfg_period_reg <= cfg_data;
            else
                cfg_step_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            cmd_reg    <= command;
            idx_reg    <= led_index;
            nmode_reg  <= new_mode;
            wstart_reg <= window_start;
            wend_reg   <= window_end;
            per_reg    <= pwm_period;
            mask_reg   <= led_mask;
            lcnt_reg   <= light_count;
        end
        led_reg  <= led_next;
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        acc_reg  <= acc_next;
        if (load_out)
        begin
            led_levels_reg    <= pin_reg;
            selected_mode_reg <= idx_ok_reg ? cur_mode : MODE_OFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_ok_reg <= 1'b0;
        end
        else if (state_reg == ST_IDLE && in_valid)
        begin
            idx_ok_reg <= idx_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_reg <= '0;
            for (int i = 0; i < LED_COUNT; i++)
            begin
                mode_tab[i]  <= MODE_OFF;
                el_tab[i]    <= '0;
                last_tab[i]  <= '0;
                start_tab[i] <= '0;
                end_tab[i]   <= '0;
                per_tab[i]   <= RESET_PERIOD;
                be_tab[i]    <= '0;
                dir_tab[i]   <= 1'b0;
            end
        end
        else
        begin
            pin_reg <= pin_next;
            if (ent_we)
            begin
                mode_tab[addr]  <= mode_n;
                el_tab[addr]    <= el_n;
                last_tab[addr]  <= last_n;
                start_tab[addr] <= start_n;
                end_tab[addr]   <= end_n;
                per_tab[addr]   <= per_n;
                be_tab[addr]    <= be_n;
                dir_tab[addr]   <= dir_n;
            end
        end
    end

endmodule
